### sv/fepi_pkg.sv
package fepi_pkg;

  // Number of rotation steps of the sine and cosine unit, clamped to the
  // length of the arctangent table.
  localparam int CORDIC_ITERATIONS = 16;
  localparam int CORDIC_STEPS = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;

  // Operand width of the bit-serial multiplier and its product width.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Dividend and divisor widths of the bit-serial divider.
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 36;

  localparam int CFG_IDX_W = 8;

  // Angle constants in Q32.32 radians.
  localparam logic [35:0] TWO_PI_Q32  = 36'd26986075409;
  localparam logic [35:0] PI_Q32      = 36'd13493037705;
  localparam logic [35:0] HALF_PI_Q32 = 36'd6746518852;
  localparam logic [35:0] WRAP_Q32    = TWO_PI_Q32 - HALF_PI_Q32;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_P_DIST        = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OMEGA0        = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_X          = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_Y          = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TI_X          = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TI_Y          = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 8'd7;

  typedef struct packed {
    logic        [31:0] time_s;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] err_x;
    logic signed [31:0] err_y;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_px;
    logic signed [31:0] ref_py;
  } out_item_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic [34:0] top;
    top = v[65:31];
    if (top == '0 || top == '1) begin
      sat32 = v[31:0];
    end else if (v[65]) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'sh7fff_ffff;
    end
  endfunction

  // atan(2^-i) in Q2.30.
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    case (idx)
      5'd0:  atan_q30 = 32'd843314857;
      5'd1:  atan_q30 = 32'd497837829;
      5'd2:  atan_q30 = 32'd263043837;
      5'd3:  atan_q30 = 32'd133525159;
      5'd4:  atan_q30 = 32'd67021687;
      5'd5:  atan_q30 = 32'd33543516;
      5'd6:  atan_q30 = 32'd16775851;
      5'd7:  atan_q30 = 32'd8388437;
      5'd8:  atan_q30 = 32'd4194283;
      5'd9:  atan_q30 = 32'd2097149;
      5'd10: atan_q30 = 32'd1048576;
      5'd11: atan_q30 = 32'd524288;
      5'd12: atan_q30 = 32'd262144;
      5'd13: atan_q30 = 32'd131072;
      5'd14: atan_q30 = 32'd65536;
      5'd15: atan_q30 = 32'd32768;
      5'd16: atan_q30 = 32'd16384;
      5'd17: atan_q30 = 32'd8192;
      5'd18: atan_q30 = 32'd4096;
      5'd19: atan_q30 = 32'd2048;
      5'd20: atan_q30 = 32'd1024;
      5'd21: atan_q30 = 32'd512;
      5'd22: atan_q30 = 32'd256;
      5'd23: atan_q30 = 32'd128;
      5'd24: atan_q30 = 32'd64;
      5'd25: atan_q30 = 32'd32;
      5'd26: atan_q30 = 32'd16;
      5'd27: atan_q30 = 32'd8;
      5'd28: atan_q30 = 32'd4;
      5'd29: atan_q30 = 32'd2;
      5'd30: atan_q30 = 32'd1;
      default: atan_q30 = 32'd0;
    endcase
  endfunction

endpackage

### sv/fepi_if.sv
interface fepi_in_if;
  logic               valid;
  logic               ready;
  fepi_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fepi_out_if;
  logic                valid;
  logic                ready;
  fepi_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fepi_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [fepi_pkg::CFG_IDX_W-1:0]     index;
  logic [31:0]                        data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/fepi_mul.sv
module fepi_mul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [fepi_pkg::MUL_W-1:0]    a,
  input  logic signed [fepi_pkg::MUL_W-1:0]    b,
  output logic                                 done,
  output logic signed [fepi_pkg::PROD_W-1:0]   prod
);
  import fepi_pkg::*;

  // Shift-add multiplier, one bit of b per cycle; the top bit of b carries
  // negative weight, so the last step subtracts.
  localparam int CNT_W = $clog2(MUL_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_W - 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic signed [MUL_W:0] hi_r, hi_nxt;
  logic [MUL_W-1:0]    lo_r, lo_nxt;
  logic signed [MUL_W:0] ext_a, addend, sum;

  always_comb begin
    ext_a  = (MUL_W + 1)'(a);
    addend = '0;
    if (lo_r[0]) begin
      addend = (cnt_r == LAST) ? -ext_a : ext_a;
    end
    sum      = hi_r + addend;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      hi_nxt   = '0;
      lo_nxt   = b;
    end else if (busy_r) begin
      hi_nxt  = {sum[MUL_W], sum[MUL_W:1]};
      lo_nxt  = {sum[0], lo_r[MUL_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r[MUL_W-1:0], lo_r};

endmodule

### sv/fepi_div.sv
module fepi_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [fepi_pkg::DIV_NUM_W-1:0]     num,
  input  logic [fepi_pkg::DIV_DEN_W-1:0]     den,
  output logic                               done,
  output logic [fepi_pkg::DIV_NUM_W-1:0]     quot,
  output logic [fepi_pkg::DIV_DEN_W-1:0]     rem
);
  import fepi_pkg::*;

  // Restoring divider: one dividend bit enters the remainder per cycle.
  localparam int CNT_W = $clog2(DIV_NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_NUM_W - 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0]  q_r, q_nxt;
  logic [DIV_DEN_W-1:0]  rem_r, rem_nxt;
  logic [DIV_DEN_W:0]    shifted;
  logic [DIV_DEN_W+1:0]  trial;

  always_comb begin
    shifted  = {rem_r, q_r[DIV_NUM_W-1]};
    trial    = {1'b0, shifted} - {2'b00, den};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (!trial[DIV_DEN_W+1]) begin
        rem_nxt = trial[DIV_DEN_W-1:0];
        q_nxt   = {q_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIV_DEN_W-1:0];
        q_nxt   = {q_r[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

### sv/figure_eight_pi_tracking_controller.sv
// One item is worked on at a time: a new input is taken only once the
// result of the last one is in the output register. Sixteen 33-step
// products in the shared bit-serial multiplier and four 64-step passes of
// the shared bit-serial divider make up nearly all of the work on an item.
// Reset (rst_n low, synchronous): configuration registers and integrators
// clear to zero, the block goes idle and the output channel empties.
module figure_eight_pi_tracking_controller (
  input logic        clk,
  input logic        rst_n,
  fepi_in_if.sink    in_if,
  fepi_out_if.source out_if,
  fepi_cfg_if.sink   cfg_if
);
  import fepi_pkg::*;

  // The controller is a sequencer over a short program. Each step uses
  // one shared resource: the serial multiplier, the serial divider (phase
  // reduction modulo 2pi and the integral gain quotient), the iterative
  // CORDIC, or a single saturating adder. Every step reads registers that
  // stay put until the step writes its own result.

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ISSUE  = 5'b00010,
    ST_WAIT   = 5'b00100,
    ST_CORDIC = 5'b01000,
    ST_FLUSH  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {K_MUL, K_DIV, K_ROT, K_ALU} kind_t;

  typedef enum logic [5:0] {
    P_PHASE_MUL, P_PHASE_MOD, P_PHASE_ROT, P_HEAD_MOD, P_HEAD_ROT,
    P_AW, P_RX, P_RY, P_VXR, P_CC, P_SS, P_DSQ, P_VYR, P_OFFX, P_OFFY,
    P_RPX, P_RPY, P_MPX, P_MPY, P_EX, P_EY,
    P_PROPX, P_KTSX, P_KIX, P_IPX, P_INTX, P_UX, P_VX,
    P_PROPY, P_KTSY, P_KIY, P_IPY, P_INTY, P_UY, P_VY
  } step_t;

  localparam logic [4:0] LAST_IT = 5'(CORDIC_STEPS - 1);

  state_t state_r, state_nxt;
  step_t  pc_r, pc_nxt;
  kind_t  kind;
  logic   commit;

  // Configuration registers.
  logic signed [31:0] p_dist_r, omega0_r, amp_r, kpx_r, kpy_r;
  logic [30:0]        tix_r, tiy_r, ts_r;

  // Item and working registers.
  in_item_t           in_r;
  logic signed [63:0] ang_r;
  logic signed [31:0] s_r, c_r, hs_r, hc_r, aw_r, rx_r, ry_r, vxr_r, vyr_r;
  logic signed [31:0] cc_r, ss_r, offx_r, offy_r, rpx_r, rpy_r, mpx_r, mpy_r;
  logic signed [31:0] ex_r, ey_r, prop_r, ki_r, ip_r, u_r, vx_r, vy_r;
  logic signed [31:0] integ_x_r, integ_y_r;

  // CORDIC datapath.
  logic signed [33:0] cx_r, cy_r, cx_nxt, cy_nxt, sx, sy;
  logic signed [36:0] cz_r, cz_nxt, at;
  logic [4:0]         cit_r;
  logic               cneg_r;
  logic signed [33:0] cos_raw, sin_raw;
  logic signed [31:0] cos_q, sin_q;

  // Shared units.
  logic                      mul_start, mul_done, div_start, div_done;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_prod;
  logic signed [31:0]        qm;
  logic signed [63:0]        div_sig;
  logic                      div_neg;
  logic [DIV_NUM_W-1:0]      div_mag, div_quot;
  logic [DIV_DEN_W-1:0]      div_den, div_rem;

  // Phase fold and integral gain.
  logic [35:0]        red;
  logic signed [36:0] red_s, fold;
  logic               fold_neg;
  logic signed [65:0] kiv;
  logic [30:0]        ti_sel;
  logic signed [31:0] ki_val;

  // Saturating adder.
  logic signed [31:0] alu_a, alu_b, alu_res;
  logic               alu_sub;
  logic signed [33:0] alu_sum;

  out_item_t out_r;
  logic      out_valid_r;

  fepi_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  fepi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_mag),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // Operand selection for the current program step.
  always_comb begin
    kind    = K_ALU;
    mul_a   = '0;
    mul_b   = '0;
    div_sig = '0;
    div_den = TWO_PI_Q32;
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (pc_r)
      P_PHASE_MUL: begin
        kind  = K_MUL;
        mul_a = MUL_W'(omega0_r);
        mul_b = {1'b0, in_r.time_s};
      end
      P_PHASE_MOD: begin
        kind    = K_DIV;
        div_sig = ang_r;
      end
      P_PHASE_ROT, P_HEAD_ROT: begin
        kind = K_ROT;
      end
      P_HEAD_MOD: begin
        kind    = K_DIV;
        div_sig = {{16{in_r.heading[31]}}, in_r.heading, 16'h0000};
      end
      P_AW: begin
        kind = K_MUL; mul_a = MUL_W'(amp_r); mul_b = MUL_W'(omega0_r);
      end
      P_RX: begin
        kind = K_MUL; mul_a = MUL_W'(amp_r); mul_b = MUL_W'(s_r);
      end
      P_RY: begin
        kind = K_MUL; mul_a = MUL_W'(rx_r); mul_b = MUL_W'(c_r);
      end
      P_VXR: begin
        kind = K_MUL; mul_a = MUL_W'(aw_r); mul_b = MUL_W'(c_r);
      end
      P_CC: begin
        kind = K_MUL; mul_a = MUL_W'(c_r); mul_b = MUL_W'(c_r);
      end
      P_SS: begin
        kind = K_MUL; mul_a = MUL_W'(s_r); mul_b = MUL_W'(s_r);
      end
      P_DSQ: begin
        alu_a = cc_r; alu_b = ss_r; alu_sub = 1'b1;
      end
      P_VYR: begin
        kind = K_MUL; mul_a = MUL_W'(aw_r); mul_b = MUL_W'(cc_r);
      end
      P_OFFX: begin
        kind = K_MUL; mul_a = MUL_W'(p_dist_r); mul_b = MUL_W'(hc_r);
      end
      P_OFFY: begin
        kind = K_MUL; mul_a = MUL_W'(p_dist_r); mul_b = MUL_W'(hs_r);
      end
      P_RPX: begin
        alu_a = rx_r; alu_b = offx_r;
      end
      P_RPY: begin
        alu_a = ry_r; alu_b = offy_r;
      end
      P_MPX: begin
        alu_a = in_r.pos_x; alu_b = offx_r;
      end
      P_MPY: begin
        alu_a = in_r.pos_y; alu_b = offy_r;
      end
      P_EX: begin
        alu_a = rpx_r; alu_b = mpx_r; alu_sub = 1'b1;
      end
      P_EY: begin
        alu_a = rpy_r; alu_b = mpy_r; alu_sub = 1'b1;
      end
      P_PROPX: begin
        kind = K_MUL; mul_a = MUL_W'(kpx_r); mul_b = MUL_W'(ex_r);
      end
      P_KTSX: begin
        kind = K_MUL; mul_a = MUL_W'(kpx_r); mul_b = {2'b00, ts_r};
      end
      P_KIX: begin
        kind = K_DIV; div_sig = ang_r; div_den = {5'b00000, tix_r};
      end
      P_IPX: begin
        kind = K_MUL; mul_a = MUL_W'(ki_r); mul_b = MUL_W'(ex_r);
      end
      P_INTX: begin
        alu_a = integ_x_r; alu_b = ip_r;
      end
      P_UX: begin
        alu_a = prop_r; alu_b = integ_x_r;
      end
      P_VX: begin
        alu_a = vxr_r; alu_b = u_r;
      end
      P_PROPY: begin
        kind = K_MUL; mul_a = MUL_W'(kpy_r); mul_b = MUL_W'(ey_r);
      end
      P_KTSY: begin
        kind = K_MUL; mul_a = MUL_W'(kpy_r); mul_b = {2'b00, ts_r};
      end
      P_KIY: begin
        kind = K_DIV; div_sig = ang_r; div_den = {5'b00000, tiy_r};
      end
      P_IPY: begin
        kind = K_MUL; mul_a = MUL_W'(ki_r); mul_b = MUL_W'(ey_r);
      end
      P_INTY: begin
        alu_a = integ_y_r; alu_b = ip_r;
      end
      P_UY: begin
        alu_a = prop_r; alu_b = integ_y_r;
      end
      P_VY: begin
        alu_a = vyr_r; alu_b = u_r;
      end
      default: begin
        kind = K_ALU;
      end
    endcase
  end

  // Unit results.
  always_comb begin
    div_neg = div_sig[63];
    div_mag = div_neg ? 64'(-div_sig) : 64'(div_sig);

    // Q16.16 product: drop 16 fraction bits rounding down, then clamp.
    qm = sat32(mul_prod >>> 16);

    alu_sum = alu_sub ? (34'(alu_a) - 34'(alu_b)) : (34'(alu_a) + 34'(alu_b));
    alu_res = sat32(66'(alu_sum));

    // Floor modulo 2pi, then fold into [-pi/2, pi/2]; a shift by pi
    // negates both sine and cosine.
    red   = (div_neg && div_rem != '0) ? (TWO_PI_Q32 - div_rem) : div_rem;
    red_s = $signed({1'b0, red});
    if (red <= HALF_PI_Q32) begin
      fold     = red_s;
      fold_neg = 1'b0;
    end else if (red < WRAP_Q32) begin
      fold     = red_s - $signed({1'b0, PI_Q32});
      fold_neg = 1'b1;
    end else begin
      fold     = red_s - $signed({1'b0, TWO_PI_Q32});
      fold_neg = 1'b0;
    end

    // Integral gain: the quotient truncates toward zero, then clamps.
    kiv    = div_neg ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
    ti_sel = (pc_r == P_KIX) ? tix_r : tiy_r;
    ki_val = (ti_sel == '0) ? 32'sd0 : sat32(kiv);
  end

  // One CORDIC rotation per cycle; a zero residual angle counts as positive.
  always_comb begin
    sx = cy_r >>> cit_r;
    sy = cx_r >>> cit_r;
    at = $signed({5'b00000, atan_q30(cit_r)});
    if (!cz_r[36]) begin
      cx_nxt = cx_r - sx;
      cy_nxt = cy_r + sy;
      cz_nxt = cz_r - at;
    end else begin
      cx_nxt = cx_r + sx;
      cy_nxt = cy_r - sy;
      cz_nxt = cz_r + at;
    end
    cos_raw = cx_nxt >>> 14;
    sin_raw = cy_nxt >>> 14;
    cos_q   = sat32(66'(cneg_r ? -cos_raw : cos_raw));
    sin_q   = sat32(66'(cneg_r ? -sin_raw : sin_raw));
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    commit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          state_nxt = ST_ISSUE;
          pc_nxt    = P_PHASE_MUL;
        end
      end
      ST_ISSUE: begin
        case (kind)
          K_MUL: begin
            mul_start = 1'b1;
            state_nxt = ST_WAIT;
          end
          K_DIV: begin
            div_start = 1'b1;
            state_nxt = ST_WAIT;
          end
          K_ROT: begin
            state_nxt = ST_CORDIC;
          end
          K_ALU: begin
            commit = 1'b1;
          end
          default: begin
            commit = 1'b1;
          end
        endcase
      end
      ST_WAIT: begin
        if (mul_done || div_done) begin
          commit = 1'b1;
        end
      end
      ST_CORDIC: begin
        if (cit_r == LAST_IT) begin
          commit = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!out_valid_r || out_if.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (commit) begin
      if (pc_r == P_VY) begin
        state_nxt = ST_FLUSH;
      end else begin
        pc_nxt    = step_t'(6'(pc_r + 6'd1));
        state_nxt = ST_ISSUE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= P_PHASE_MUL;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_dist_r <= '0;
      omega0_r <= '0;
      amp_r    <= '0;
      kpx_r    <= '0;
      kpy_r    <= '0;
      tix_r    <= '0;
      tiy_r    <= '0;
      ts_r     <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_P_DIST:        p_dist_r <= cfg_if.data;
        CFG_OMEGA0:        omega0_r <= cfg_if.data;
        CFG_AMPLITUDE:     amp_r    <= cfg_if.data;
        CFG_KP_X:          kpx_r    <= cfg_if.data;
        CFG_KP_Y:          kpy_r    <= cfg_if.data;
        CFG_TI_X:          tix_r    <= cfg_if.data[30:0];
        CFG_TI_Y:          tiy_r    <= cfg_if.data[30:0];
        CFG_SAMPLE_PERIOD: ts_r     <= cfg_if.data[30:0];
        default: begin
        end
      endcase
    end
  end

  // Integrators, cleared by reset and updated once per item and axis.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_x_r <= '0;
      integ_y_r <= '0;
    end else if (commit && pc_r == P_INTX) begin
      integ_x_r <= alu_res;
    end else if (commit && pc_r == P_INTY) begin
      integ_y_r <= alu_res;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_if.valid) begin
      in_r <= in_if.data;
    end
    if (commit) begin
      case (pc_r)
        P_PHASE_MUL: ang_r  <= mul_prod[63:0];
        P_PHASE_ROT: begin
          s_r <= sin_q;
          c_r <= cos_q;
        end
        P_HEAD_ROT: begin
          hs_r <= sin_q;
          hc_r <= cos_q;
        end
        P_AW:    aw_r   <= qm;
        P_RX:    rx_r   <= qm;
        P_RY:    ry_r   <= qm;
        P_VXR:   vxr_r  <= qm;
        P_CC:    cc_r   <= qm;
        P_SS:    ss_r   <= qm;
        P_DSQ:   cc_r   <= alu_res;
        P_VYR:   vyr_r  <= qm;
        P_OFFX:  offx_r <= qm;
        P_OFFY:  offy_r <= qm;
        P_RPX:   rpx_r  <= alu_res;
        P_RPY:   rpy_r  <= alu_res;
        P_MPX:   mpx_r  <= alu_res;
        P_MPY:   mpy_r  <= alu_res;
        P_EX:    ex_r   <= alu_res;
        P_EY:    ey_r   <= alu_res;
        P_PROPX, P_PROPY: prop_r <= qm;
        P_KTSX, P_KTSY:   ang_r  <= mul_prod[63:0];
        P_KIX, P_KIY:     ki_r   <= ki_val;
        P_IPX, P_IPY:     ip_r   <= qm;
        P_UX, P_UY:       u_r    <= alu_res;
        P_VX:    vx_r   <= alu_res;
        P_VY:    vy_r   <= alu_res;
        default: begin
        end
      endcase
    end
  end

  // CORDIC registers: loaded when a phase reduction completes.
  always_ff @(posedge clk) begin
    if (state_r == ST_CORDIC) begin
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      cz_r  <= cz_nxt;
      cit_r <= cit_r + 1'b1;
    end else if (commit && (pc_r == P_PHASE_MOD || pc_r == P_HEAD_MOD)) begin
      cx_r   <= CORDIC_GAIN_Q30;
      cy_r   <= '0;
      cz_r   <= fold >>> 2;
      cneg_r <= fold_neg;
      cit_r  <= '0;
    end
  end

  // Output register: holds a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FLUSH && (!out_valid_r || out_if.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FLUSH && (!out_valid_r || out_if.ready)) begin
      out_r.vel_x  <= vx_r;
      out_r.vel_y  <= vy_r;
      out_r.err_x  <= ex_r;
      out_r.err_y  <= ey_r;
      out_r.ref_x  <= rx_r;
      out_r.ref_y  <= ry_r;
      out_r.ref_px <= rpx_r;
      out_r.ref_py <= rpy_r;
    end
  end

  assign in_if.ready  = (state_r == ST_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;
  assign cfg_if.ready = 1'b1;

endmodule

### sv/fepi_checker.sv
module fepi_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fepi_pkg::out_item_t out_data
);
  import fepi_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted transaction");

  // A new result only appears at the end of work on an item.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the block was idle");

endmodule

bind figure_eight_pi_tracking_controller fepi_checker u_fepi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

### test/figure_eight_pi_tracking_controller_tb.sv
`timescale 1ns / 100ps

module figure_eight_pi_tracking_controller_tb;
  import fepi_pkg::*;

  // Phase constants in Q32.32 radians, used by the sine and cosine predictor.
  localparam longint TWO_PI_FX  = 64'sd26986075409;
  localparam longint PI_FX      = 64'sd13493037705;
  localparam longint HALF_PI_FX = 64'sd6746518852;
  localparam longint GAIN_FX    = 64'sd652032874;
  localparam int     ROT_STEPS  = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
  localparam longint S32_MAX    = 64'sd2147483647;
  localparam longint S32_MIN    = -64'sd2147483648;
  localparam int     NUM_REGS   = 8;
  localparam int     NUM_RANDOM = 1850;
  localparam int     RAND_PHASES = 12;
  localparam int     DRAIN_CYCLES = 900;

  logic clk;
  logic rst_n;

  fepi_in_if  in_if ();
  fepi_out_if out_if ();
  fepi_cfg_if cfg_if ();

  figure_eight_pi_tracking_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // One row of the directed table. When known is set, the expected result is
  // typed in by hand; otherwise it comes from the predictor.
  typedef struct {
    int        setting;
    in_item_t  item;
    bit        known;
    out_item_t result;
  } dir_row_t;

  typedef longint reg_set_t [NUM_REGS];

  // Register images kept by the predictor, plus its two integrators.
  longint    ctrl_reg [NUM_REGS];
  longint    integ_x;
  longint    integ_y;
  out_item_t pending_cmds [$];
  int        mismatches;
  bit        calm;
  int        out_hold;

  longint atan_tab [32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
    524288, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8,
    4, 2, 1, 0
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Absolute limit on the run, far above the slowest legal schedule.
  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint sat_q(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Q16.16 product: arithmetic shift floors, just like the block's datapath.
  function automatic longint mul_q(longint a, longint b);
    return sat_q((a * b) >>> 16);
  endfunction

  function automatic longint add_q(longint a, longint b);
    return sat_q(a + b);
  endfunction

  // Reduce a Q32.32 angle into [-pi/2, pi/2], remembering a half turn as a
  // sign flip, then rotate with the arctangent table in Q2.30.
  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint r;
    longint x;
    longint y;
    longint z;
    longint nx;
    bit     flip;
    r = ang % TWO_PI_FX;
    x = GAIN_FX;
    y = 0;
    flip = 1'b0;
    if (r < 0) r += TWO_PI_FX;
    if (r >= PI_FX) r -= TWO_PI_FX;
    if (r > HALF_PI_FX) begin
      r -= PI_FX;
      flip = 1'b1;
    end else if (r < -HALF_PI_FX) begin
      r += PI_FX;
      flip = 1'b1;
    end
    z = r >>> 2;
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_tab[i];
      end
      x = nx;
    end
    x = x >>> 14;
    y = y >>> 14;
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = sat_q(y);
    c = sat_q(x);
  endfunction

  // One axis of the PI law; the integrator is updated before it is used.
  function automatic longint pi_axis(input longint meas, input longint setp, input longint kp,
                                     input longint ti, inout longint integ,
                                     output longint err);
    longint ki;
    err = add_q(setp, -meas);
    ki = 0;
    if (ti > 0) ki = sat_q((kp * ctrl_reg[CFG_SAMPLE_PERIOD]) / ti);
    integ = add_q(integ, mul_q(ki, err));
    return add_q(mul_q(kp, err), integ);
  endfunction

  // Full control step: reference, feedforward, shift to point P, PI per axis.
  function automatic out_item_t predict_command(in_item_t item);
    longint    s, c, hs, hc;
    longint    aw, rx, ry, vxr, vyr, offx, offy, rpx, rpy, mpx, mpy, ex, ey, ux, uy;
    out_item_t r;
    sin_cos(ctrl_reg[CFG_OMEGA0] * longint'({32'b0, item.time_s}), s, c);
    sin_cos(longint'(item.heading) * 65536, hs, hc);
    aw   = mul_q(ctrl_reg[CFG_AMPLITUDE], ctrl_reg[CFG_OMEGA0]);
    rx   = mul_q(ctrl_reg[CFG_AMPLITUDE], s);
    ry   = mul_q(rx, c);
    vxr  = mul_q(aw, c);
    vyr  = mul_q(aw, add_q(mul_q(c, c), -mul_q(s, s)));
    offx = mul_q(ctrl_reg[CFG_P_DIST], hc);
    offy = mul_q(ctrl_reg[CFG_P_DIST], hs);
    rpx  = add_q(rx, offx);
    rpy  = add_q(ry, offy);
    mpx  = add_q(longint'(item.pos_x), offx);
    mpy  = add_q(longint'(item.pos_y), offy);
    ux   = pi_axis(mpx, rpx, ctrl_reg[CFG_KP_X], ctrl_reg[CFG_TI_X], integ_x, ex);
    uy   = pi_axis(mpy, rpy, ctrl_reg[CFG_KP_Y], ctrl_reg[CFG_TI_Y], integ_y, ey);
    r.vel_x  = add_q(vxr, ux);
    r.vel_y  = add_q(vyr, uy);
    r.err_x  = ex;
    r.err_y  = ey;
    r.ref_x  = rx;
    r.ref_y  = ry;
    r.ref_px = rpx;
    r.ref_py = rpy;
    return r;
  endfunction

  // Gap length: mostly none or short, occasionally long.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // Result with everything zero except the errors, which is what a block
  // holding its reset registers produces.
  function automatic out_item_t idle_result(logic signed [31:0] ex, logic signed [31:0] ey);
    out_item_t r;
    r = '0;
    r.err_x = ex;
    r.err_y = ey;
    return r;
  endfunction

  // Each write waits for a clock edge after the previous one was dropped, so
  // valid is never driven twice in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx < NUM_REGS) begin
      if (idx >= CFG_TI_X) ctrl_reg[idx] = longint'({33'b0, value[30:0]});
      else ctrl_reg[idx] = longint'(signed'(value));
    end
  endtask

  // Registers change only while nothing is in flight, so wait for the
  // outstanding results and a short settle before writing.
  task automatic apply_setting(input reg_set_t vals, input bit poke_unused);
    wait (pending_cmds.size() == 0);
    repeat (4) @(posedge clk);
    for (int i = 0; i < NUM_REGS; i++) write_reg(i[CFG_IDX_W-1:0], vals[i][31:0]);
    if (poke_unused) write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 255)), $urandom());
  endtask

  // Send one input transaction, optionally after an idle gap. The expected
  // result is computed at the accepting edge, with the registers then in force.
  // The block is not ready again until it has worked through the item, so the
  // edge spent with valid low costs nothing.
  task automatic send_sample(input in_item_t item, input bit known, input out_item_t given);
    int        gap;
    out_item_t predicted;
    gap = pick_gap();
    @(posedge clk);
    repeat (gap) @(posedge clk);
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    do @(posedge clk); while (!in_if.ready);
    predicted = predict_command(item);
    pending_cmds.push_back(known ? given : predicted);
    in_if.valid <= 1'b0;
  endtask

  function automatic longint rand_q(int mag);
    return longint'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  function automatic longint pick_signed_reg(int mag);
    case ($urandom_range(0, 9))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2:       return longint'(signed'($urandom()));
      default: return rand_q(mag);
    endcase
  endfunction

  function automatic longint pick_time_reg(int hi);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return S32_MAX;
      2:       return longint'($urandom() & 32'h7fff_ffff);
      default: return longint'($urandom_range(1, hi));
    endcase
  endfunction

  function automatic in_item_t random_sample();
    in_item_t item;
    item.time_s  = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 32'h0064_0000);
    item.pos_x   = ($urandom_range(0, 9) == 0) ? $urandom() : 32'(rand_q(32'h0010_0000));
    item.pos_y   = ($urandom_range(0, 9) == 0) ? $urandom() : 32'(rand_q(32'h0010_0000));
    item.heading = ($urandom_range(0, 9) == 0) ? $urandom() : 32'(rand_q(32'h0008_0000));
    return item;
  endfunction

  // Compare each delivered result with the oldest outstanding expectation.
  always @(posedge clk) begin
    out_item_t want;
    logic [255:0] want_bits;
    logic [255:0] got_bits;
    string field_name [8];
    field_name = '{"vel_x", "vel_y", "err_x", "err_y", "ref_x", "ref_y", "ref_px", "ref_py"};
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transaction %h", $time, out_if.data);
      end else begin
        want = pending_cmds.pop_front();
        want_bits = want;
        got_bits = out_if.data;
        for (int k = 0; k < 8; k++) begin
          if (want_bits[255 - 32 * k -: 32] !== got_bits[255 - 32 * k -: 32]) begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, field_name[k],
                     want_bits[255 - 32 * k -: 32], got_bits[255 - 32 * k -: 32]);
          end
        end
      end
    end
  end

  // The result side stalls on its own schedule, independent of the sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_hold <= 0;
    end else if (out_hold > 0) begin
      out_if.ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_hold <= pick_gap();
    end
  end

  initial begin
    dir_row_t  rows [$];
    reg_set_t  sets [4];
    reg_set_t  rnd;
    dir_row_t  row;
    int        cur_set;
    int        per_phase;

    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    rst_n        <= 1'b0;
    mismatches = 0;
    calm = 1'b0;
    integ_x = 0;
    integ_y = 0;
    foreach (ctrl_reg[i]) ctrl_reg[i] = 0;

    // Setting zero is the reset state. The next two put every register at an
    // extreme, one with the shortest and longest integral times, the other
    // with integration switched off. The last one is a plausible tuning.
    sets[0] = '{0, 0, 0, 0, 0, 0, 0, 0};
    sets[1] = '{S32_MAX, S32_MIN, S32_MAX, S32_MAX, S32_MIN, 1, S32_MAX, S32_MAX};
    sets[2] = '{S32_MIN, S32_MAX, S32_MIN, S32_MIN, S32_MAX, 0, 0, 0};
    sets[3] = '{32'h8000, 32'h10000, 32'h20000, 32'h8000, 32'hc000, 32'h10000, 32'h20000, 328};

    // With reset registers the reference and feedforward are zero, so only
    // the errors move, and they saturate at the negated extremes.
    rows.push_back('{0, '{32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, idle_result(0, 0)});
    rows.push_back('{0, '{32'hffff_ffff, 32'h8000_0000, 32'h0, 32'h0}, 1'b1,
                     idle_result(32'h7fff_ffff, 32'h0)});
    rows.push_back('{0, '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}, 1'b1,
                     idle_result(32'h8000_0001, 32'h7fff_ffff)});
    rows.push_back('{0, '{32'h1234_5678, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000}, 1'b1,
                     idle_result(32'hffff_0000, 32'h8000_0001)});
    rows.push_back('{0, '{32'h0, 32'hffff_ffff, 32'h1, 32'h0}, 1'b1,
                     idle_result(32'h1, 32'hffff_ffff)});
    // Extreme gains and times: products and integrators hit their limits.
    rows.push_back('{1, '{32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0});
    rows.push_back('{1, '{32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b0, '0});
    rows.push_back('{1, '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0});
    rows.push_back('{1, '{32'h0001_0000, 32'h0, 32'h0, 32'h0003_243f}, 1'b0, '0});
    rows.push_back('{1, '{32'h0001_0000, 32'h0, 32'h0, 32'h0003_243f}, 1'b0, '0});
    rows.push_back('{1, '{32'h0000_0001, 32'hffff_0000, 32'h0001_0000, 32'hfffe_6de1}, 1'b0, '0});
    // Integration disabled: the integrators must hold what they had.
    rows.push_back('{2, '{32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0});
    rows.push_back('{2, '{32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0});
    rows.push_back('{2, '{32'h0000_ffff, 32'h0001_0000, 32'hffff_0000, 32'h0001_921f}, 1'b0, '0});
    rows.push_back('{2, '{32'h8000_0000, 32'h0, 32'h0, 32'h7fff_ffff}, 1'b0, '0});
    // A normal tuning, walking time through several quarter turns.
    rows.push_back('{3, '{32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0});
    rows.push_back('{3, '{32'h0001_921f, 32'h0000_8000, 32'hffff_8000, 32'h0001_921f}, 1'b0, '0});
    rows.push_back('{3, '{32'h0003_243f, 32'h0001_0000, 32'h0, 32'h0003_243f}, 1'b0, '0});
    rows.push_back('{3, '{32'h0004_b65f, 32'hffff_0000, 32'h0001_0000, 32'hfffb_49a1}, 1'b0, '0});
    rows.push_back('{3, '{32'h0006_487f, 32'h0, 32'h0002_0000, 32'h0}, 1'b0, '0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_set = 0;
    foreach (rows[i]) begin
      row = rows[i];
      if (row.setting != cur_set) begin
        cur_set = row.setting;
        apply_setting(sets[cur_set], cur_set == 2);
      end
      send_sample(row.item, row.known, row.result);
    end

    // Random phases: each one starts from idle with a fresh register set,
    // mostly moderate values so that saturation does not hide the math.
    per_phase = NUM_RANDOM / RAND_PHASES;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      rnd[CFG_P_DIST]        = pick_signed_reg(32'h0002_0000);
      rnd[CFG_OMEGA0]        = pick_signed_reg(32'h0004_0000);
      rnd[CFG_AMPLITUDE]     = pick_signed_reg(32'h0008_0000);
      rnd[CFG_KP_X]          = pick_signed_reg(32'h0004_0000);
      rnd[CFG_KP_Y]          = pick_signed_reg(32'h0004_0000);
      rnd[CFG_TI_X]          = pick_time_reg(32'h0004_0000);
      rnd[CFG_TI_Y]          = pick_time_reg(32'h0004_0000);
      rnd[CFG_SAMPLE_PERIOD] = pick_time_reg(6554);
      apply_setting(rnd, $urandom_range(0, 3) == 0);
      // Every fourth phase runs with no idling on either side.
      calm = (ph % 4 == 3);
      for (int n = 0; n < per_phase; n++) begin
        send_sample(random_sample(), 1'b0, '0);
        // Now and then the sender holds off until the block has emptied.
        if ($urandom_range(0, 49) == 0) wait (pending_cmds.size() == 0);
      end
    end
    calm = 1'b0;

    wait (pending_cmds.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
